// ===== src/ile_pkg.sv =====
// ----------------------------------------------------------------------------
// ile_pkg: shared types and constants of the indexed list engine
// Command and status codes, the per-cell operation code and the command
// beat that is broadcast along the row of storage cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ile_pkg;

  // Width of one list entry.
  localparam int DataW = 32;

  // Number of cells folded into one register of the read-out tree.
  localparam int GrpSize = 32;

  // Command codes on the input channel.
  typedef enum logic [2:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_SET    = 3'd3,
    CMD_GET    = 3'd4
  } cmd_e;

  // Status codes on the result channel.
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // What every cell does with its entry.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_WRITE  = 2'd3
  } cell_op_e;

  // Command broadcast to all cells.
  typedef struct packed {
    logic                    load;   // a beat is taken this cycle
    logic                    rd;     // the beat reads the entry at the index
    cell_op_e                op;
    logic signed [DataW-1:0] value;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== src/ile_cell.sv =====
// ----------------------------------------------------------------------------
// ile_cell: one storage cell of the list
// Holds the entry at a fixed list position, takes the entry of its left or
// right neighbor when the list opens or closes, and offers its entry for a
// read when the broadcast index names its position.
// ----------------------------------------------------------------------------
`default_nettype none

module ile_cell #(
  parameter int Pos  = 0,
  parameter int CmpW = 8
) (
  input  wire                               clk_i,
  input  wire ile_pkg::cell_cmd_t           cmd_i,
  input  wire logic [CmpW-1:0]              idx_i,
  input  wire logic signed [ile_pkg::DataW-1:0] left_i,
  input  wire logic signed [ile_pkg::DataW-1:0] right_i,
  output logic signed [ile_pkg::DataW-1:0]  data_o,
  output logic signed [ile_pkg::DataW-1:0]  rd_o
);
  import ile_pkg::*;

  logic signed [DataW-1:0] data_q;
  logic signed [DataW-1:0] rd_q;
  logic                    hit;
  logic                    above;

  // Position of this cell against the broadcast index.
  assign hit   = (CmpW'(Pos) == idx_i);
  assign above = (CmpW'(Pos) >  idx_i);

  // Entry update: shift up on insert, shift down on remove, load on write.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CELL_INSERT: begin
        if (above) begin
          data_q <= left_i;
        end else if (hit) begin
          data_q <= cmd_i.value;
        end
      end
      CELL_REMOVE: begin
        if (above || hit) begin
          data_q <= right_i;
        end
      end
      CELL_WRITE: begin
        if (hit) begin
          data_q <= cmd_i.value;
        end
      end
      default: begin
      end
    endcase
  end

  // Read-out register: the entry when this cell is read, zero otherwise.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rd_q <= (cmd_i.rd && hit) ? data_q : '0;
    end
  end

  assign data_o = data_q;
  assign rd_o   = rd_q;

endmodule

`default_nettype wire

// ===== src/indexed_list_engine.sv =====
// ----------------------------------------------------------------------------
// indexed_list_engine: ordered list of signed 32-bit entries
// A row of DEPTH cells holds the list; commands append, insert, remove,
// set or get entries and each returns one result beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries cmd_i, index_i and
//   value_i. Output channel (out_valid_o / out_stall_i) carries read_value_o,
//   status_o and count_o, one result beat per command, in command order.
//   The whole row of cells updates at the edge where a command is taken, so
//   a shift of any length is done at that edge and the next command sees it.
//   A taken command passes three registers on its way to the result beat:
//   the cell read-out register, a register per group of 32 cells, and the
//   output register. Throughput is one command per cycle while the output
//   does not stall; the three result registers are a pipeline whose stages
//   each load when empty or when the stage after them moves.
//   When the receiver stalls, the pipeline fills and in_stall_o rises once
//   the cell read-out stage cannot hand on its beat.
//   Reset clears the entry count and all stage valid flags; entries are not
//   cleared, as no entry is read before it is written.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_engine #(
  parameter int DEPTH = 64
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [2:0]                       cmd_i,
  input  wire logic [7:0]                       index_i,
  input  wire logic signed [ile_pkg::DataW-1:0] value_i,
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic signed [ile_pkg::DataW-1:0]      read_value_o,
  output logic [1:0]                            status_o,
  output logic [$clog2(DEPTH+1)-1:0]            count_o
);
  import ile_pkg::*;

  localparam int CntW   = $clog2(DEPTH + 1);
  localparam int CmpW   = (CntW > 8) ? CntW : 8;
  localparam int NumGrp = (DEPTH + GrpSize - 1) / GrpSize;

  // Entry count and decode of the incoming command.
  logic [CntW-1:0]   count_q, count_d;
  logic              in_acc;
  logic [CmpW-1:0]   idx_ext, cnt_ext, cell_idx;
  logic              idx_le, idx_lt, full;
  cell_cmd_t         cell_cmd;
  status_e           status_d;
  logic              neg_d;

  // Pipeline stage flags and payload.
  logic              b_v_q, c_v_q, o_v_q;
  logic              b_ok, c_ok, o_ok;
  status_e           b_status_q, c_status_q;
  logic [CntW-1:0]   b_count_q, c_count_q;
  logic              b_neg_q, c_neg_q;
  logic signed [DataW-1:0] grp_q [NumGrp];
  logic signed [DataW-1:0] grp_d [NumGrp];
  logic signed [DataW-1:0] rd_all;

  logic signed [DataW-1:0] out_value_q;
  status_e                 out_status_q;
  logic [CntW-1:0]         out_count_q;

  // Cell row buses.
  logic signed [DataW-1:0] cell_data [DEPTH];
  logic signed [DataW-1:0] cell_rd   [DEPTH];

  // Each stage loads when empty or when the stage after it moves on.
  assign o_ok       = !o_v_q || !out_stall_i;
  assign c_ok       = !c_v_q || o_ok;
  assign b_ok       = !b_v_q || c_ok;
  assign in_stall_o = !b_ok;
  assign in_acc     = in_valid_i && b_ok;

  assign idx_ext = CmpW'(index_i);
  assign cnt_ext = CmpW'(count_q);
  assign idx_le  = (idx_ext <= cnt_ext);
  assign idx_lt  = (idx_ext <  cnt_ext);
  assign full    = (count_q == CntW'(DEPTH));

  // Command decode into a cell operation, status and new count.
  always_comb begin
    cell_cmd.load  = in_acc;
    cell_cmd.rd    = 1'b0;
    cell_cmd.op    = CELL_HOLD;
    cell_cmd.value = value_i;
    cell_idx       = idx_ext;
    status_d       = ST_OK;
    neg_d          = 1'b0;
    count_d        = count_q;
    case (cmd_i)
      CMD_APPEND: begin
        cell_idx = cnt_ext;
        if (full) begin
          status_d = ST_FULL;
        end else begin
          cell_cmd.op = CELL_INSERT;
          count_d     = count_q + CntW'(1);
        end
      end
      CMD_INSERT: begin
        if (!idx_le) begin
          status_d = ST_BAD;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          cell_cmd.op = CELL_INSERT;
          count_d     = count_q + CntW'(1);
        end
      end
      CMD_REMOVE: begin
        if (!idx_lt) begin
          status_d = ST_BAD;
        end else begin
          cell_cmd.op = CELL_REMOVE;
          count_d     = count_q - CntW'(1);
        end
      end
      CMD_SET: begin
        if (!idx_lt) begin
          status_d = ST_BAD;
        end else begin
          cell_cmd.op = CELL_WRITE;
        end
      end
      CMD_GET: begin
        if (!idx_lt) begin
          status_d = ST_BAD;
          neg_d    = 1'b1;
        end else begin
          cell_cmd.rd = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (!in_acc) begin
      cell_cmd.op = CELL_HOLD;
      count_d     = count_q;
    end
  end

  // Row of storage cells; each sees its two neighbors.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic signed [DataW-1:0] left_w, right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_inner_l
      assign left_w = cell_data[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner_r
      assign right_w = cell_data[k+1];
    end
    ile_cell #(
      .Pos  (k),
      .CmpW (CmpW)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cell_cmd),
      .idx_i   (cell_idx),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[k]),
      .rd_o    (cell_rd[k])
    );
  end

  // Entry count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (b_ok) b_v_q <= in_acc;
      if (c_ok) c_v_q <= b_v_q;
      if (o_ok) o_v_q <= c_v_q;
    end
  end

  // Group OR of the cell read-out registers; only the read cell is nonzero.
  always_comb begin
    for (int g = 0; g < NumGrp; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < GrpSize; j++) begin
        if (g * GrpSize + j < DEPTH) begin
          grp_d[g] = grp_d[g] | cell_rd[g * GrpSize + j];
        end
      end
    end
  end

  // Final OR across the group registers.
  always_comb begin
    rd_all = '0;
    for (int g = 0; g < NumGrp; g++) begin
      rd_all = rd_all | grp_q[g];
    end
  end

  // Payload of the result pipeline.
  always_ff @(posedge clk_i) begin
    if (b_ok && in_acc) begin
      b_status_q <= status_d;
      b_count_q  <= count_d;
      b_neg_q    <= neg_d;
    end
    if (c_ok && b_v_q) begin
      c_status_q <= b_status_q;
      c_count_q  <= b_count_q;
      c_neg_q    <= b_neg_q;
      grp_q      <= grp_d;
    end
    if (o_ok && c_v_q) begin
      out_value_q  <= c_neg_q ? '1 : rd_all;
      out_status_q <= c_status_q;
      out_count_q  <= c_count_q;
    end
  end

  assign out_valid_o  = o_v_q;
  assign read_value_o = out_value_q;
  assign status_o     = out_status_q;
  assign count_o      = out_count_q;

  // The count never passes the number of cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count above depth");

  // A full status is only reported with every cell in use.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> (count_o == CntW'(DEPTH)))
    else $error("full status with free cells");

  // An append that finds room grows the list by one.
  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (cmd_i == CMD_APPEND) && !full |=> count_q == $past(count_q) + CntW'(1))
    else $error("append did not grow the list");

  // A full status always comes with a zero read value.
  a_bad_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> (read_value_o == '0))
    else $error("nonzero read value on full status");

  // Input stalls only while every result stage holds a beat and the receiver stalls.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> b_v_q && c_v_q && o_v_q && out_stall_i)
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

// ===== dv/indexed_list_engine_tb.sv =====
// ----------------------------------------------------------------------------
// indexed_list_engine_tb: self-checking testbench of the indexed list engine
// A queue-fed driver sends append, insert, remove, set and get commands. A
// monitor keeps a shadow copy of the list, computes the result of every
// accepted command beat and checks the result beats against it in order.
// Both channels idle and stall in short random bursts. The run ends with a
// stretch of full-rate traffic.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ile_pkg::*;

  localparam int Depth       = 64;
  localparam int CountW      = $clog2(Depth + 1);
  localparam int IdxW        = $clog2(Depth);
  localparam int CycleLimit  = 400000;
  localparam int RandomItems = 1850;
  localparam int ReportMax   = 10;

  // Traffic shape of one random phase.
  typedef enum logic [1:0] {
    MIX_GROW,
    MIX_SHRINK,
    MIX_EVEN
  } mix_e;

  // One command beat.
  typedef struct {
    logic [2:0]              cmd;
    logic [7:0]              index;
    logic signed [DataW-1:0] value;
  } list_cmd_t;

  // One result beat.
  typedef struct {
    logic signed [DataW-1:0] read_value;
    status_e                 status;
    logic [CountW-1:0]       count;
  } list_result_t;

  logic                    clk_i;
  logic                    rst_ni       = 1'b0;
  logic                    in_valid_i   = 1'b0;
  logic                    in_stall_o;
  logic [2:0]              cmd_i        = '0;
  logic [7:0]              index_i      = '0;
  logic signed [DataW-1:0] value_i      = '0;
  logic                    out_valid_o;
  logic                    out_stall_i  = 1'b0;
  logic signed [DataW-1:0] read_value_o;
  logic [1:0]              status_o;
  logic [CountW-1:0]       count_o;

  // Commands waiting to be driven and results waiting to arrive.
  list_cmd_t    cmd_queue[$];
  list_result_t list_results[$];

  // Shadow copy of the list, updated at every accepted command beat.
  logic signed [DataW-1:0] shadow_list[Depth];
  int                      shadow_len = 0;

  // Length of the list as the stimulus generator expects it to be.
  int gen_len = 0;

  int  beats_queued   = 0;
  int  beats_accepted = 0;
  bit  beat_taken     = 1'b0;
  int  gap_left       = 0;
  int  stall_left     = 0;
  int  gap_pct        = 0;
  int  stall_pct      = 0;
  int  errors         = 0;
  int  cycle_count    = 0;

  indexed_list_engine #(
    .DEPTH(Depth)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .index_i     (index_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_value_o(read_value_o),
    .status_o    (status_o),
    .count_o     (count_o)
  );

  // Clock with a 10 ns period.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Applies one command to the shadow list and returns the result it gives.
  function automatic list_result_t apply_command(logic [2:0] cmd, logic [7:0] idx,
                                                 logic signed [DataW-1:0] val);
    list_result_t res;
    int           k;
    res.read_value = '0;
    res.status     = ST_OK;
    case (cmd)
      CMD_APPEND: begin
        if (shadow_len >= Depth) begin
          res.status = ST_FULL;
        end else begin
          shadow_list[IdxW'(shadow_len)] = val;
          shadow_len++;
        end
      end
      CMD_INSERT: begin
        // The index is checked before the store is checked for room.
        if (int'(idx) > shadow_len) begin
          res.status = ST_BAD;
        end else if (shadow_len >= Depth) begin
          res.status = ST_FULL;
        end else begin
          for (k = shadow_len; k > int'(idx); k--) begin
            shadow_list[IdxW'(k)] = shadow_list[IdxW'(k-1)];
          end
          shadow_list[IdxW'(idx)] = val;
          shadow_len++;
        end
      end
      CMD_REMOVE: begin
        if (int'(idx) >= shadow_len) begin
          res.status = ST_BAD;
        end else begin
          for (k = int'(idx); k + 1 < shadow_len; k++) begin
            shadow_list[IdxW'(k)] = shadow_list[IdxW'(k+1)];
          end
          shadow_len--;
        end
      end
      CMD_SET: begin
        if (int'(idx) >= shadow_len) res.status = ST_BAD;
        else shadow_list[IdxW'(idx)] = val;
      end
      CMD_GET: begin
        if (int'(idx) >= shadow_len) begin
          res.status     = ST_BAD;
          res.read_value = -1;
        end else begin
          res.read_value = shadow_list[IdxW'(idx)];
        end
      end
      default: begin
        // Unknown commands leave the list alone and report ok.
      end
    endcase
    res.count = CountW'(shadow_len);
    return res;
  endfunction

  // Queues one command and tracks the list length it leads to.
  task automatic queue_command(logic [2:0] cmd, logic [7:0] idx, logic signed [DataW-1:0] val);
    list_cmd_t c;
    c.cmd   = cmd;
    c.index = idx;
    c.value = val;
    case (cmd)
      CMD_APPEND: if (gen_len < Depth) gen_len++;
      CMD_INSERT: if (int'(idx) <= gen_len && gen_len < Depth) gen_len++;
      CMD_REMOVE: if (int'(idx) < gen_len) gen_len--;
      default: ;
    endcase
    cmd_queue.push_back(c);
    beats_queued++;
  endtask

  // Builds one random command, biased by the traffic shape of the phase.
  task automatic queue_random(mix_e mix);
    int                      r;
    int                      pick;
    logic [2:0]              cmd;
    logic [7:0]              idx;
    logic signed [DataW-1:0] val;
    int                      lim[4];
    r = $urandom_range(99);
    case (mix)
      MIX_GROW:   lim = '{40, 75, 82, 90};
      MIX_SHRINK: lim = '{5, 10, 75, 85};
      default:    lim = '{20, 40, 60, 78};
    endcase
    if (r < lim[0]) cmd = CMD_APPEND;
    else if (r < lim[1]) cmd = CMD_INSERT;
    else if (r < lim[2]) cmd = CMD_REMOVE;
    else if (r < lim[3]) cmd = CMD_SET;
    else if (r < 98) cmd = CMD_GET;
    else cmd = 3'($urandom_range(5, 7));

    // Mostly in-range positions, with the edges and wild values mixed in.
    pick = $urandom_range(99);
    if (pick < 10 || cmd > CMD_GET) begin
      idx = 8'($urandom_range(255));
    end else if (cmd == CMD_INSERT) begin
      if (pick < 20) idx = 8'(gen_len + 1);
      else idx = 8'($urandom_range(gen_len));
    end else if (pick < 20 || gen_len == 0) begin
      idx = 8'(gen_len);
    end else begin
      idx = 8'($urandom_range(gen_len - 1));
    end

    case ($urandom_range(39))
      0:       val = 32'sh8000_0000;
      1:       val = 32'sh7fff_ffff;
      2:       val = -1;
      3:       val = 0;
      default: val = $urandom;
    endcase
    queue_command(cmd, idx, val);
  endtask

  // Holds the sender until every queued beat has been taken and answered.
  task automatic wait_drained();
    while (beats_accepted != beats_queued || list_results.size() != 0) @(posedge clk_i);
  endtask

  // Command driver: presents queued beats at the falling edge, with gaps.
  always @(negedge clk_i) begin
    list_cmd_t c;
    if (rst_ni && !(in_valid_i && !beat_taken)) begin
      beat_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
        c = cmd_queue.pop_front();
        in_valid_i <= 1'b1;
        cmd_i      <= c.cmd;
        index_i    <= c.index;
        value_i    <= c.value;
        if ($urandom_range(99) < gap_pct) gap_left = $urandom_range(1, 3);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result stall driver: raises out_stall_i in random bursts.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (rst_ni && $urandom_range(99) < stall_pct) begin
      stall_left = $urandom_range(0, 2);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Monitor: checks result beats, then records accepted command beats.
  always @(posedge clk_i) begin
    list_result_t want;
    bit           bad;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (list_results.size() == 0) begin
          errors++;
          if (errors <= ReportMax)
            $display("Unexpected result beat: read_value %0d status %0d count %0d",
                     read_value_o, status_o, count_o);
        end else begin
          want = list_results.pop_front();
          bad  = (read_value_o !== want.read_value) || (status_o !== want.status) ||
                 (count_o !== want.count);
          if (bad) begin
            errors++;
            if (errors <= ReportMax)
              $display("Mismatch at cycle %0d: read_value %0d/%0d status %0d/%0d count %0d/%0d",
                       cycle_count, want.read_value, read_value_o, want.status, status_o,
                       want.count, count_o);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        list_results.push_back(apply_command(cmd_i, index_i, value_i));
        beats_accepted++;
        beat_taken = 1'b1;
      end
    end
  end

  // Stimulus: directed commands, then random phases, then the verdict.
  initial begin
    int   sent;
    int   phase;
    int   len;
    int   j;
    mix_e mix;

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: extreme values, every command, bad indexes, unknown codes.
    queue_command(CMD_GET, 8'd0, 0);
    queue_command(CMD_APPEND, 8'd0, 32'sh8000_0000);
    queue_command(CMD_APPEND, 8'd0, 32'sh7fff_ffff);
    queue_command(CMD_APPEND, 8'd255, -1);
    queue_command(CMD_INSERT, 8'd0, 0);
    queue_command(CMD_INSERT, 8'd4, 32'sh1234_5678);
    queue_command(CMD_INSERT, 8'd6, 32'sh0bad_0bad);
    for (j = 0; j < 5; j++) queue_command(CMD_GET, 8'(j), 0);
    queue_command(CMD_GET, 8'd5, 0);
    queue_command(CMD_GET, 8'd255, 0);
    queue_command(CMD_SET, 8'd2, 32'sh5a5a_a5a5);
    queue_command(CMD_SET, 8'd5, 7);
    queue_command(CMD_REMOVE, 8'd5, 0);
    queue_command(CMD_REMOVE, 8'd0, 0);
    queue_command(CMD_REMOVE, 8'd3, 0);
    queue_command(CMD_GET, 8'd2, 0);
    queue_command(3'd5, 8'd0, 32'sh7fff_ffff);
    queue_command(3'd6, 8'd128, -1);
    queue_command(3'd7, 8'd255, 32'sh8000_0000);
    queue_command(CMD_REMOVE, 8'd200, 0);
    queue_command(CMD_GET, 8'd1, 0);

    // Let the whole directed part come back before random traffic starts.
    wait_drained();

    // Random phases; the first one fills the list up to the full case.
    sent  = 0;
    phase = 0;
    while (sent < RandomItems) begin
      while (cmd_queue.size() > 1) @(posedge clk_i);
      if (phase == 5) wait_drained();
      len = $urandom_range(100, 200);
      if (phase == 0) mix = MIX_GROW;
      else mix = mix_e'($urandom_range(2));
      if (RandomItems - sent <= 300) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(2))
          0:       gap_pct = 0;
          1:       gap_pct = 10;
          default: gap_pct = 30;
        endcase
        case ($urandom_range(2))
          0:       stall_pct = 0;
          1:       stall_pct = 10;
          default: stall_pct = 30;
        endcase
      end
      for (j = 0; j < len && sent < RandomItems; j++) begin
        queue_random(mix);
        sent++;
      end
      phase++;
    end

    // Drain, allow the pipeline latency to pass, then decide.
    wait_drained();
    repeat (8) @(posedge clk_i);
    errors += list_results.size();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
